// ----- rtl/core/jpp_pkg.sv -----
// Shared types and constants for the JSON pretty printer core.
// Holds the request structs, character codes and controller/datapath links.
// No dependencies.
package jpp_pkg;

    localparam int unsigned BYTE_W        = 8;
    localparam int unsigned DEPTH_W       = 3;
    localparam int unsigned WIDTH_W       = 3;
    localparam int unsigned MAX_DEPTH_DEF = 7;
    localparam int unsigned WIDTH_RESET   = 4;
    localparam int unsigned WIDTH_MAX     = 4;

    localparam logic [BYTE_W-1:0] CH_NEWLINE   = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_SPACE     = 8'h20;
    localparam logic [BYTE_W-1:0] CH_TILDE     = 8'h7E;
    localparam logic [BYTE_W-1:0] CH_BACKSLASH = 8'h5C;
    localparam logic [BYTE_W-1:0] CH_QUOTE     = 8'h22;
    localparam logic [BYTE_W-1:0] CH_COLON     = 8'h3A;
    localparam logic [BYTE_W-1:0] CH_COMMA     = 8'h2C;
    localparam logic [BYTE_W-1:0] CH_LBRACE    = 8'h7B;
    localparam logic [BYTE_W-1:0] CH_RBRACE    = 8'h7D;
    localparam logic [BYTE_W-1:0] CH_LBRACKET  = 8'h5B;
    localparam logic [BYTE_W-1:0] CH_RBRACKET  = 8'h5D;

    typedef struct packed {
        logic [BYTE_W-1:0] in_byte;
        logic              end_of_text;
    } in_item_t;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              last_of_run;
        logic              fault;
    } out_item_t;

    // Where the next output byte comes from.
    typedef enum logic [1:0] {
        SEL_LEAD,
        SEL_C1,
        SEL_MID,
        SEL_C2
    } src_sel_t;

    typedef struct packed {
        logic     load;
        logic     emit;
        src_sel_t sel;
        logic     last;
    } dp_cmd_t;

    typedef struct packed {
        logic lead_nz;
        logic lead_one;
        logic c1_en;
        logic mid_nz;
        logic mid_one;
        logic c2_en;
        logic slot_free;
    } dp_status_t;

endpackage

// ----- rtl/core/jpp_ctrl.sv -----
// Sequencing controller for the JSON pretty printer.
// Walks the segments of one request's plan and drives the datapath.
// Depends on jpp_pkg.
module jpp_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  jpp_pkg::dp_status_t    status,
    output jpp_pkg::dp_cmd_t       cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PLAN,
        S_LEAD,
        S_C1,
        S_MID,
        S_C2
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   stall_reg;
    logic   stall_next;

    state_t after_lead;
    state_t after_c1;
    state_t after_mid;

    // First non-empty segment following each position, or idle.
    always_comb
    begin
        after_mid  = status.c2_en  ? S_C2  : S_IDLE;
        after_c1   = status.mid_nz ? S_MID : after_mid;
        after_lead = status.c1_en  ? S_C1  : after_c1;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.sel    = jpp_pkg::SEL_LEAD;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_PLAN;
                end
            end
            S_PLAN:
            begin
                state_next = status.lead_nz ? S_LEAD : after_lead;
            end
            S_LEAD:
            begin
                if (status.slot_free)
                begin
                    cmd.emit = 1'b1;
                    cmd.sel  = jpp_pkg::SEL_LEAD;
                    if (status.lead_one)
                    begin
                        cmd.last   = (after_lead == S_IDLE);
                        state_next = after_lead;
                    end
                end
            end
            S_C1:
            begin
                if (status.slot_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.sel    = jpp_pkg::SEL_C1;
                    cmd.last   = (after_c1 == S_IDLE);
                    state_next = after_c1;
                end
            end
            S_MID:
            begin
                if (status.slot_free)
                begin
                    cmd.emit = 1'b1;
                    cmd.sel  = jpp_pkg::SEL_MID;
                    if (status.mid_one)
                    begin
                        cmd.last   = (after_mid == S_IDLE);
                        state_next = after_mid;
                    end
                end
            end
            S_C2:
            begin
                if (status.slot_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.sel    = jpp_pkg::SEL_C2;
                    cmd.last   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        stall_next = (state_next != S_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            stall_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            stall_reg <= stall_next;
        end
    end

    assign in_stall = stall_reg;

endmodule

// ----- rtl/core/jpp_datapath.sv -----
// Datapath of the JSON pretty printer: parser state, output plan and
// output register. Driven by jpp_ctrl through command and status structs.
// Depends on jpp_pkg.
module jpp_datapath #(
    parameter int unsigned MAX_DEPTH = jpp_pkg::MAX_DEPTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  jpp_pkg::in_item_t                  in_item,
    input  logic                               cfg_we,
    input  logic [jpp_pkg::WIDTH_W-1:0]        cfg_data,
    input  jpp_pkg::dp_cmd_t                   cmd,
    output jpp_pkg::dp_status_t                status,
    output logic                               out_valid,
    input  logic                               out_stall,
    output jpp_pkg::out_item_t                 out_item
);

    localparam int unsigned DW    = jpp_pkg::DEPTH_W;
    localparam int unsigned WW    = jpp_pkg::WIDTH_W;
    localparam int unsigned BW    = jpp_pkg::BYTE_W;
    localparam int unsigned CNT_W = $clog2(MAX_DEPTH * jpp_pkg::WIDTH_MAX + 1);
    localparam int unsigned PW    = DW + WW;

    // Configuration and parser state.
    logic [WW-1:0] width_reg;
    logic [DW-1:0] depth_reg, depth_next;
    logic          armed_reg, armed_next;
    logic          instr_reg, instr_next;
    logic          esc_reg, esc_next;
    logic          stopped_reg, stopped_next;

    // Output plan for the current request.
    logic [CNT_W-1:0] lead_reg, lead_next;
    logic [CNT_W-1:0] mid_reg, mid_next;
    logic             c1_en_reg, c1_en_next;
    logic             c2_en_reg, c2_en_next;
    logic [BW-1:0]    c1_reg, c1_next;
    logic [BW-1:0]    c2_reg, c2_next;
    logic             fault_reg, fault_next;

    logic               out_valid_reg;
    jpp_pkg::out_item_t out_item_reg;

    logic [WW-1:0] w_eff;
    logic [DW-1:0] depth_dec;
    logic [PW-1:0] lead_prod;
    logic [PW-1:0] mid_prod;
    logic [BW-1:0] b;
    logic          is_open, is_close;

    assign b         = in_item.in_byte;
    assign w_eff     = (width_reg > WW'(jpp_pkg::WIDTH_MAX)) ? WW'(jpp_pkg::WIDTH_MAX)
                                                               : width_reg;
    assign depth_dec = depth_reg - DW'(1);
    assign lead_prod = PW'(depth_reg) * PW'(w_eff);
    assign mid_prod  = PW'(depth_dec) * PW'(w_eff);
    assign is_open   = (b == jpp_pkg::CH_LBRACE) || (b == jpp_pkg::CH_LBRACKET);
    assign is_close  = (b == jpp_pkg::CH_RBRACE) || (b == jpp_pkg::CH_RBRACKET);

    always_comb
    begin
        depth_next   = depth_reg;
        armed_next   = armed_reg;
        instr_next   = instr_reg;
        esc_next     = esc_reg;
        stopped_next = stopped_reg;
        lead_next    = '0;
        mid_next     = '0;
        c1_en_next   = 1'b0;
        c2_en_next   = 1'b0;
        c1_next      = b;
        c2_next      = b;
        fault_next   = 1'b0;

        if (!stopped_reg)
        begin
            if (instr_reg)
            begin
                c1_en_next = 1'b1;
                if (esc_reg)
                begin
                    esc_next = 1'b0;
                end
                else if (b == jpp_pkg::CH_BACKSLASH)
                begin
                    esc_next = 1'b1;
                end
                else if (b == jpp_pkg::CH_QUOTE)
                begin
                    instr_next = 1'b0;
                end
            end
            else
            begin
                if (armed_reg)
                begin
                    lead_next = CNT_W'(lead_prod);
                end
                armed_next = 1'b0;
                if (is_open)
                begin
                    c1_en_next = 1'b1;
                    c2_en_next = 1'b1;
                    c2_next    = jpp_pkg::CH_NEWLINE;
                    armed_next = 1'b1;
                    if (depth_reg >= DW'(MAX_DEPTH))
                    begin
                        fault_next = 1'b1;
                    end
                    else
                    begin
                        depth_next = depth_reg + DW'(1);
                    end
                end
                else if (is_close)
                begin
                    // The newline goes first and the close byte last.
                    c1_en_next = 1'b1;
                    c1_next    = jpp_pkg::CH_NEWLINE;
                    c2_en_next = 1'b1;
                    if (depth_reg == '0)
                    begin
                        fault_next   = 1'b1;
                        stopped_next = 1'b1;
                    end
                    else
                    begin
                        depth_next = depth_dec;
                        mid_next   = CNT_W'(mid_prod);
                    end
                end
                else if (b == jpp_pkg::CH_COLON)
                begin
                    c1_en_next = 1'b1;
                    c2_en_next = 1'b1;
                    c2_next    = jpp_pkg::CH_SPACE;
                end
                else if (b == jpp_pkg::CH_COMMA)
                begin
                    c1_en_next = 1'b1;
                    c2_en_next = 1'b1;
                    c2_next    = jpp_pkg::CH_NEWLINE;
                    armed_next = 1'b1;
                end
                else if (b == jpp_pkg::CH_QUOTE)
                begin
                    c1_en_next = 1'b1;
                    instr_next = 1'b1;
                    esc_next   = 1'b0;
                end
                else if ((b > jpp_pkg::CH_SPACE) && (b <= jpp_pkg::CH_TILDE))
                begin
                    c1_en_next = 1'b1;
                end
            end
        end

        if (in_item.end_of_text)
        begin
            depth_next   = '0;
            armed_next   = 1'b0;
            instr_next   = 1'b0;
            esc_next     = 1'b0;
            stopped_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg   <= WW'(jpp_pkg::WIDTH_RESET);
            depth_reg   <= '0;
            armed_reg   <= 1'b0;
            instr_reg   <= 1'b0;
            esc_reg     <= 1'b0;
            stopped_reg <= 1'b0;
            lead_reg    <= '0;
            mid_reg     <= '0;
            c1_en_reg   <= 1'b0;
            c2_en_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                width_reg <= cfg_data;
            end
            if (cmd.load)
            begin
                depth_reg   <= depth_next;
                armed_reg   <= armed_next;
                instr_reg   <= instr_next;
                esc_reg     <= esc_next;
                stopped_reg <= stopped_next;
                lead_reg    <= lead_next;
                mid_reg     <= mid_next;
                c1_en_reg   <= c1_en_next;
                c2_en_reg   <= c2_en_next;
            end
            else if (cmd.emit && (cmd.sel == jpp_pkg::SEL_LEAD))
            begin
                lead_reg <= lead_reg - CNT_W'(1);
            end
            else if (cmd.emit && (cmd.sel == jpp_pkg::SEL_MID))
            begin
                mid_reg <= mid_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            c1_reg    <= c1_next;
            c2_reg    <= c2_next;
            fault_reg <= fault_next;
        end
    end

    // Output register: a new byte may be written once the old one is taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            case (cmd.sel)
                jpp_pkg::SEL_C1: out_item_reg.out_byte <= c1_reg;
                jpp_pkg::SEL_C2: out_item_reg.out_byte <= c2_reg;
                default:         out_item_reg.out_byte <= jpp_pkg::CH_SPACE;
            endcase
            out_item_reg.last_of_run <= cmd.last;
            out_item_reg.fault       <= fault_reg;
        end
    end

    assign status.lead_nz   = (lead_reg != '0);
    assign status.lead_one  = (lead_reg == CNT_W'(1));
    assign status.c1_en     = c1_en_reg;
    assign status.mid_nz    = (mid_reg != '0);
    assign status.mid_one   = (mid_reg == CNT_W'(1));
    assign status.c2_en     = c2_en_reg;
    assign status.slot_free = !out_valid_reg || !out_stall;

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

// ----- rtl/core/json_pretty_printer_core.sv -----
// Top level of the JSON pretty printer core.
// Joins the controller (jpp_ctrl) and the datapath (jpp_datapath); uses jpp_pkg.
//
// Usage: JSON text enters one byte per request on the in channel (in_valid,
// in_stall, in_item); re-indented text leaves one byte per request on the out
// channel (out_valid, out_stall, out_item). A request is taken at a clock edge
// with valid high and stall low. in_item.end_of_text marks the final byte of
// a text; the parser state returns to its reset value after that byte.
// The indent width is written on the cfg channel (cfg_valid, cfg_ready,
// cfg_data) by the user only while the block is idle; the block does not
// enforce this. cfg_ready is always high.
// Sequence: an input byte is taken, its output plan is formed in the next
// cycle, and then its N output bytes follow at one per cycle through the
// output register while the receiver does not stall.
// N is up to 54 at the default depth, set by indentation runs of spaces.
// The next input is taken as soon as the last byte of the previous one sits
// in the output register.
// A stalled receiver holds the output register and the sequence pauses.
// Reset clears the parser state, empties the output register and sets the
// indent width to four.
module json_pretty_printer_core #(
    parameter int unsigned MAX_DEPTH = jpp_pkg::MAX_DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  jpp_pkg::in_item_t             in_item,
    output logic                          out_valid,
    input  logic                          out_stall,
    output jpp_pkg::out_item_t            out_item,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [jpp_pkg::WIDTH_W-1:0]   cfg_data
);

    jpp_pkg::dp_cmd_t    cmd;
    jpp_pkg::dp_status_t status;
    logic                cfg_we;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    jpp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    jpp_datapath #(
        .MAX_DEPTH (MAX_DEPTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_item   (in_item),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

    // A new byte is never written over one that is still waiting.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> status.slot_free)
        else $error("output byte written while the previous one was stalled");

    // After a request is taken the input side is held off.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input taken while a request was still in work");

    // The final byte of a request frees the input side.
    a_last_frees_input: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && cmd.last) |=> !in_stall)
        else $error("input still held after the final byte of a request");

endmodule

// ----- tb/json_pretty_printer_core_tb.sv -----
// Self-checking testbench for json_pretty_printer_core.
// A scoreboard class predicts the re-indented byte stream; tasks drive the channels.
// Depends on jpp_pkg and the json_pretty_printer_core RTL.
`timescale 1ns / 100ps

module json_pretty_printer_core_tb;

    localparam int CYCLE_LIMIT = 500000;
    localparam int SETTLE_CYCLES = 8;
    localparam int WW = jpp_pkg::WIDTH_W;

    // Predicts the printer's output and holds the bytes still to arrive.
    class printer_scoreboard;
        jpp_pkg::out_item_t expected_q[$];
        logic [7:0] run_bytes[$];
        logic [WW-1:0] indent_width;
        int unsigned nest;
        bit armed;
        bit in_string;
        bit escaped;
        bit halted;
        int errors;

        function new();
            indent_width = WW'(jpp_pkg::WIDTH_RESET);
            errors = 0;
            clear_parser();
        endfunction

        function void clear_parser();
            nest = 0;
            armed = 0;
            in_string = 0;
            escaped = 0;
            halted = 0;
        endfunction

        function void set_width(logic [WW-1:0] w);
            indent_width = w;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void add_spaces(int unsigned levels);
            int unsigned eff;
            eff = (indent_width > jpp_pkg::WIDTH_MAX) ? jpp_pkg::WIDTH_MAX : indent_width;
            repeat (levels * eff) run_bytes.push_back(jpp_pkg::CH_SPACE);
        endfunction

        function void note_request(jpp_pkg::in_item_t req);
            logic [7:0] b;
            bit bad;
            jpp_pkg::out_item_t e;
            b = req.in_byte;
            bad = 0;
            run_bytes.delete();
            if (!halted)
            begin
                if (in_string)
                begin
                    run_bytes.push_back(b);
                    if (escaped)
                        escaped = 0;
                    else if (b == jpp_pkg::CH_BACKSLASH)
                        escaped = 1;
                    else if (b == jpp_pkg::CH_QUOTE)
                        in_string = 0;
                end
                else
                begin
                    // A pending indent goes out before any byte, even one that is dropped.
                    if (armed)
                    begin
                        add_spaces(nest);
                        armed = 0;
                    end
                    if (b == jpp_pkg::CH_LBRACE || b == jpp_pkg::CH_LBRACKET)
                    begin
                        run_bytes.push_back(b);
                        run_bytes.push_back(jpp_pkg::CH_NEWLINE);
                        if (nest >= jpp_pkg::MAX_DEPTH_DEF)
                            bad = 1;
                        else
                            nest++;
                        armed = 1;
                    end
                    else if (b == jpp_pkg::CH_RBRACE || b == jpp_pkg::CH_RBRACKET)
                    begin
                        run_bytes.push_back(jpp_pkg::CH_NEWLINE);
                        if (nest == 0)
                        begin
                            bad = 1;
                            halted = 1;
                        end
                        else
                        begin
                            nest--;
                            add_spaces(nest);
                        end
                        run_bytes.push_back(b);
                    end
                    else if (b == jpp_pkg::CH_COLON)
                    begin
                        run_bytes.push_back(b);
                        run_bytes.push_back(jpp_pkg::CH_SPACE);
                    end
                    else if (b == jpp_pkg::CH_COMMA)
                    begin
                        run_bytes.push_back(b);
                        run_bytes.push_back(jpp_pkg::CH_NEWLINE);
                        armed = 1;
                    end
                    else if (b == jpp_pkg::CH_QUOTE)
                    begin
                        run_bytes.push_back(b);
                        in_string = 1;
                        escaped = 0;
                    end
                    else if (b > jpp_pkg::CH_SPACE && b <= jpp_pkg::CH_TILDE)
                    begin
                        run_bytes.push_back(b);
                    end
                end
            end
            foreach (run_bytes[k])
            begin
                e.out_byte = run_bytes[k];
                e.last_of_run = (k == run_bytes.size() - 1);
                e.fault = bad;
                expected_q.push_back(e);
            end
            if (req.end_of_text)
                clear_parser();
        endfunction

        function void report(string what, jpp_pkg::out_item_t want, jpp_pkg::out_item_t got);
            errors++;
            if (errors <= 10)
                $display("%0t: %s: expected byte %h last %b fault %b, got byte %h last %b fault %b",
                         $time, what, want.out_byte, want.last_of_run, want.fault,
                         got.out_byte, got.last_of_run, got.fault);
        endfunction

        function void check_result(jpp_pkg::out_item_t got);
            jpp_pkg::out_item_t want;
            if (expected_q.size() == 0)
            begin
                want = '0;
                report("unexpected byte", want, got);
                return;
            end
            want = expected_q.pop_front();
            if (got.out_byte !== want.out_byte || got.last_of_run !== want.last_of_run
                || got.fault !== want.fault)
                report("mismatch", want, got);
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    jpp_pkg::in_item_t in_item = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    jpp_pkg::out_item_t out_item;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [WW-1:0] cfg_data = '0;

    printer_scoreboard sb = new();
    int send_idle_pct = 9;
    int recv_idle_pct = 83;
    int hold_left = 0;
    int cycle_count = 0;

    json_pretty_printer_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("json_pretty_printer_core_tb NOT OK");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            sb.note_request(in_item);
        if (rst_n && out_valid && !out_stall)
            sb.check_result(out_item);
    end

    // Receiver: random stalls, or a long hold-off when one has been asked for.
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else
        begin
            out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    // Entered and left at a falling edge; valid stays high on return.
    task automatic send_byte(input jpp_pkg::in_item_t item);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item <= item;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain_outputs();
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_width(input logic [WW-1:0] w);
        drain_outputs();
        cfg_valid <= 1'b1;
        cfg_data <= w;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        sb.set_width(w);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_directed();
        logic [7:0] text[$];
        jpp_pkg::in_item_t item;
        // Nest to the limit, overflow once, then the widest close; strings with an
        // escaped quote; dropped bytes; and an unbalanced close that halts the text.
        text = '{jpp_pkg::CH_LBRACE, jpp_pkg::CH_LBRACKET, jpp_pkg::CH_LBRACE,
                 jpp_pkg::CH_LBRACKET, jpp_pkg::CH_LBRACE, jpp_pkg::CH_LBRACKET,
                 jpp_pkg::CH_LBRACE, jpp_pkg::CH_LBRACKET, jpp_pkg::CH_RBRACE,
                 jpp_pkg::CH_QUOTE, jpp_pkg::CH_BACKSLASH, jpp_pkg::CH_QUOTE,
                 8'hFF, jpp_pkg::CH_QUOTE, jpp_pkg::CH_COLON, jpp_pkg::CH_SPACE,
                 jpp_pkg::CH_COMMA, 8'h7F, 8'h21, jpp_pkg::CH_TILDE,
                 8'h00, jpp_pkg::CH_RBRACKET, 8'h78, jpp_pkg::CH_LBRACE};
        foreach (text[k])
        begin
            item.in_byte = text[k];
            item.end_of_text = (k == 20 || k == 23);
            send_byte(item);
        end
    endtask

    // One text of roughly well-formed JSON with random content, last byte flagged.
    task automatic send_text(input int n_bytes, input int open_pct, output int sent);
        logic [7:0] text[$];
        jpp_pkg::in_item_t item;
        int depth;
        int pick;
        int len;
        depth = 0;
        while (text.size() < n_bytes)
        begin
            pick = $urandom_range(0, 99);
            if (pick < open_pct)
            begin
                text.push_back($urandom_range(0, 1) ? jpp_pkg::CH_LBRACE : jpp_pkg::CH_LBRACKET);
                depth++;
            end
            else if (pick < open_pct + 18)
            begin
                if (depth > 0 || $urandom_range(0, 19) == 0)
                begin
                    text.push_back($urandom_range(0, 1) ? jpp_pkg::CH_RBRACE
                                                        : jpp_pkg::CH_RBRACKET);
                    if (depth > 0)
                        depth--;
                end
            end
            else if (pick < open_pct + 28)
            begin
                text.push_back(jpp_pkg::CH_COLON);
            end
            else if (pick < open_pct + 38)
            begin
                text.push_back(jpp_pkg::CH_COMMA);
            end
            else if (pick < open_pct + 50)
            begin
                text.push_back(jpp_pkg::CH_QUOTE);
                len = $urandom_range(0, 5);
                repeat (len)
                begin
                    if ($urandom_range(0, 5) == 0)
                    begin
                        text.push_back(jpp_pkg::CH_BACKSLASH);
                        text.push_back(8'($urandom_range(0, 255)));
                    end
                    else if ($urandom_range(0, 3) == 0)
                    begin
                        text.push_back(8'($urandom_range(0, 255)));
                    end
                    else
                    begin
                        text.push_back(8'($urandom_range(jpp_pkg::CH_SPACE, jpp_pkg::CH_TILDE)));
                    end
                end
                text.push_back(jpp_pkg::CH_QUOTE);
            end
            else if (pick < 95)
            begin
                text.push_back(8'($urandom_range(8'h21, jpp_pkg::CH_TILDE)));
            end
            else
            begin
                text.push_back(8'($urandom_range(0, 255)));
            end
        end
        foreach (text[k])
        begin
            item.in_byte = text[k];
            item.end_of_text = (k == text.size() - 1);
            send_byte(item);
        end
        sent = text.size();
    endtask

    task automatic run_texts(input int n_bytes);
        int sent;
        int total;
        total = 0;
        while (total < n_bytes)
        begin
            // Now and then a text biased towards deep nesting and overflow.
            send_text($urandom_range(4, 24), ($urandom_range(0, 4) == 0) ? 40 : 22, sent);
            total += sent;
        end
    endtask

    initial
    begin
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send_directed();
        write_width(WW'(0));
        run_texts(16);
        write_width(WW'(7));
        // Long hold-off on the receiver while requests keep coming.
        @(posedge clk);
        hold_left = 300;
        @(negedge clk);
        run_texts(16);

        write_width(WW'(2));
        send_idle_pct = 83;
        recv_idle_pct = 9;
        run_texts(16);
        write_width(WW'(5));
        run_texts(8);
        drain_outputs();
        run_texts(8);

        write_width(WW'(4));
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_texts(16);
        write_width(WW'(1));
        run_texts(12);

        drain_outputs();
        repeat (20) @(negedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("json_pretty_printer_core_tb OK");
        else
            $display("json_pretty_printer_core_tb NOT OK");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/core/jpp_pkg.sv
rtl/core/jpp_ctrl.sv
rtl/core/jpp_datapath.sv
rtl/core/json_pretty_printer_core.sv
tb/json_pretty_printer_core_tb.sv
